// File: design/sh24_pkg.sv
// Package for the SipHash-2-4 stream hasher: constants, state word type,
// sequencer and round-kind enums. Depends on nothing.
package sh24_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned LEN_W      = 8;
    localparam int unsigned BYTES_W    = 8;   // bytes in one word
    localparam int unsigned OFF_W      = 3;   // byte offset within a word
    localparam int unsigned LEN_SHIFT  = 56;  // length byte position in pad word
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [COUNT_W-1:0] MAX_BYTES = COUNT_W'(BYTES_W);

    localparam logic [WORD_W-1:0] SIP_C0   = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] SIP_C1   = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] SIP_C2   = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] SIP_C3   = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] FIN_XOR  = 64'h00000000000000ff;

    // Half-round counts per pass, minus one
    localparam logic [2:0] ABSORB_LAST = 3'd3;  // two rounds
    localparam logic [2:0] FINAL_LAST  = 3'd7;  // four rounds

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW  = 2'd0,
        CFG_KEY_HIGH = 2'd1
    } sh24_cfg_idx_t;

    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] v2;
        logic [WORD_W-1:0] v3;
    } sip_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MERGE,
        ST_PAD,
        ST_ROUND,
        ST_MIX,
        ST_DONE
    } sh24_state_t;

    typedef enum logic [1:0] {
        KIND_MSG,
        KIND_PAD,
        KIND_FINAL
    } sh24_kind_t;

endpackage

// File: design/siphash_2_4_stream_hasher_core.sv
// Top level of the keyed SipHash-2-4 stream hasher: input merge, sequencer,
// output register. Depends on sh24_pkg and sh24_half_round.
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  input   | s_valid s_ready s_message_bytes            | in
//          | s_byte_count s_last                        |
//  result  | m_valid m_ready m_hash_value               | out
//  config  | cfg_wr_en cfg_index cfg_wdata              | in
//
// One half-SipRound unit serves every round, each round as two halves. An
// item that completes a word is absorbed with two rounds; last then absorbs
// the length pad word, runs four final rounds and loads the output register.
// s_ready is high only while the sequencer is idle; a held result stalls only
// the output load and keeps its value until taken. Reset (aresetn, sync)
// clears both keys and loads the state from the SipHash constants.
module siphash_2_4_stream_hasher_core
    import sh24_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_W-1:0]    s_message_bytes,
    input  logic [COUNT_W-1:0]   s_byte_count,
    input  logic                 s_last,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WORD_W-1:0]    m_hash_value,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_wdata
);

    sh24_state_t          state_reg, state_next;
    sh24_kind_t           kind_reg, kind_next;
    sip_state_t           v_reg, v_next, v_round;
    logic [WORD_W-1:0]    key_low_reg, key_low_next;
    logic [WORD_W-1:0]    key_high_reg, key_high_next;
    logic [WORD_W-1:0]    partial_reg, partial_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [WORD_W-1:0]    msg_reg, msg_next;
    logic [WORD_W-1:0]    data_reg, data_next;
    logic [COUNT_W-1:0]   n_reg, n_next;
    logic                 last_reg, last_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]    hash_reg, hash_next;

    logic [COUNT_W-1:0]   in_count;
    logic [WORD_W-1:0]    in_masked;
    logic [OFF_W-1:0]     offset;
    logic [COUNT_W-1:0]   fill_sum;
    logic                 word_full;
    logic [2*WORD_W-1:0]  shifted;
    logic [WORD_W-1:0]    merged_word;
    logic [WORD_W-1:0]    pad_word;
    logic [2:0]           round_last;
    logic                 round_end;
    logic                 out_free;
    logic                 key_write;

    // Shared round unit
    sh24_half_round u_round (
        .v_in  (v_reg),
        .phase (cnt_reg[0]),
        .v_out (v_round)
    );

    // Saturate the byte count and drop bytes past it
    always_comb begin
        in_count = (s_byte_count > MAX_BYTES) ? MAX_BYTES : s_byte_count;
        for (int i = 0; i < BYTES_W; i++) begin
            in_masked[i*8 +: 8] = (COUNT_W'(i) < in_count) ? s_message_bytes[i*8 +: 8]
                                                            : 8'h00;
        end
    end

    // Place the new bytes after those already in the partial word
    assign offset      = len_reg[OFF_W-1:0];
    assign fill_sum    = COUNT_W'(offset) + n_reg;
    assign word_full   = (fill_sum >= MAX_BYTES);
    assign shifted     = {{WORD_W{1'b0}}, data_reg} << {offset, 3'b000};
    assign merged_word = partial_reg | shifted[WORD_W-1:0];
    assign pad_word    = partial_reg | ({{(WORD_W-LEN_W){1'b0}}, len_reg} << LEN_SHIFT);

    assign round_last  = (kind_reg == KIND_FINAL) ? FINAL_LAST : ABSORB_LAST;
    assign round_end   = (cnt_reg == round_last);
    assign out_free    = !out_valid_reg || m_ready;
    assign key_write   = cfg_wr_en &&
                         (cfg_index == CFG_KEY_LOW || cfg_index == CFG_KEY_HIGH);

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_hash_value = hash_reg;

    // Key register decode
    always_comb begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_KEY_LOW:  key_low_next  = cfg_wdata;
                CFG_KEY_HIGH: key_high_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_MERGE;
            end
            ST_MERGE: begin
                if (word_full)     state_next = ST_ROUND;
                else if (last_reg) state_next = ST_PAD;
                else               state_next = ST_IDLE;
            end
            ST_PAD: begin
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                if (round_end) begin
                    state_next = (kind_reg == KIND_FINAL) ? ST_DONE : ST_MIX;
                end
            end
            ST_MIX: begin
                if (kind_reg == KIND_MSG) state_next = last_reg ? ST_PAD : ST_IDLE;
                else                      state_next = ST_ROUND;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath next values
    always_comb begin
        v_next         = v_reg;
        kind_next      = kind_reg;
        partial_next   = partial_reg;
        len_next       = len_reg;
        msg_next       = msg_reg;
        data_next      = data_reg;
        n_next         = n_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg;

        // Drop the result once taken
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    data_next = in_masked;
                    n_next    = in_count;
                    last_next = s_last;
                end
            end
            ST_MERGE: begin
                len_next = len_reg + LEN_W'(n_reg);
                if (word_full) begin
                    // Absorb the completed word, keep the overflow bytes
                    v_next.v3    = v_reg.v3 ^ merged_word;
                    msg_next     = merged_word;
                    partial_next = shifted[2*WORD_W-1:WORD_W];
                    kind_next    = KIND_MSG;
                    cnt_next     = 3'd0;
                end else begin
                    partial_next = merged_word;
                end
            end
            ST_PAD: begin
                v_next.v3 = v_reg.v3 ^ pad_word;
                msg_next  = pad_word;
                kind_next = KIND_PAD;
                cnt_next  = 3'd0;
            end
            ST_ROUND: begin
                v_next   = v_round;
                cnt_next = cnt_reg + 3'd1;
            end
            ST_MIX: begin
                v_next.v0 = v_reg.v0 ^ msg_reg;
                if (kind_reg == KIND_PAD) begin
                    v_next.v2 = v_reg.v2 ^ FIN_XOR;
                    kind_next = KIND_FINAL;
                    cnt_next  = 3'd0;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    hash_next      = v_reg.v0 ^ v_reg.v1 ^ v_reg.v2 ^ v_reg.v3;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase

        // Start a fresh message after a hash or a key write
        if ((state_reg == ST_DONE && out_free) || key_write) begin
            v_next.v0    = key_low_next  ^ SIP_C0;
            v_next.v1    = key_high_next ^ SIP_C1;
            v_next.v2    = key_low_next  ^ SIP_C2;
            v_next.v3    = key_high_next ^ SIP_C3;
            partial_next = '0;
            len_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_MSG;
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            v_reg         <= '{v0: SIP_C0, v1: SIP_C1, v2: SIP_C2, v3: SIP_C3};
            partial_reg   <= '0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            key_low_reg   <= key_low_next;
            key_high_reg  <= key_high_next;
            v_reg         <= v_next;
            partial_reg   <= partial_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        msg_reg  <= msg_next;
        data_reg <= data_next;
        n_reg    <= n_next;
        last_reg <= last_next;
        hash_reg <= hash_next;
    end

endmodule

// File: design/sh24_half_round.sv
// Shared SipRound unit: one half of a SipRound per cycle, selected by phase.
// Depends on sh24_pkg.
module sh24_half_round
    import sh24_pkg::*;
(
    input  sip_state_t v_in,
    input  logic       phase,
    output sip_state_t v_out
);

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned r);
        rotl = (x << r) | (x >> (WORD_W - r));
    endfunction

    logic [WORD_W-1:0] sum_a;
    logic [WORD_W-1:0] sum_c;

    always_comb begin
        if (!phase) begin
            // first half: a += b, c += d
            sum_a    = v_in.v0 + v_in.v1;
            sum_c    = v_in.v2 + v_in.v3;
            v_out.v0 = rotl(sum_a, 32);
            v_out.v1 = rotl(v_in.v1, 13) ^ sum_a;
            v_out.v2 = sum_c;
            v_out.v3 = rotl(v_in.v3, 16) ^ sum_c;
        end else begin
            // second half: a += d, c += b
            sum_a    = v_in.v0 + v_in.v3;
            sum_c    = v_in.v2 + v_in.v1;
            v_out.v0 = sum_a;
            v_out.v1 = rotl(v_in.v1, 17) ^ sum_c;
            v_out.v2 = rotl(sum_c, 32);
            v_out.v3 = rotl(v_in.v3, 21) ^ sum_a;
        end
    end

endmodule
